/* design/dpcmdn_pkg.sv */
package dpcmdn_pkg;

    localparam int MAX_LEN_DEF = 65536;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = 32;
    localparam int RUN_W      = 48;
    localparam int VAL_W      = 49;
    localparam int WIN_W      = 16;
    localparam int DIV_STEPS  = 64;
    localparam int NDIV_STEPS = 15;

    localparam logic [NDIV_STEPS-1:0] NORM_SCALE = 15'd30000;

    typedef struct packed {
        logic load;
        logic pass_start;
        logic p1_acc;
        logic p1_init;
        logic div_step;
        logic p1_wr;
        logic p2_x;
        logic p2_wr;
        logic idx_inc;
        logic set_ready;
        logic sel_rp;
        logic mul_lo;
        logic mul_hi;
        logic ndiv_step;
        logic out_data;
        logic out_empty;
    } t_cmd;

    typedef struct packed {
        logic detrend;
        logic idx_last;
        logic div_last;
        logic ndiv_last;
        logic rd_ok;
        logic out_free;
    } t_stat;

endpackage

/* design/dpcmdn_ctrl.sv */
module dpcmdn_ctrl
    import dpcmdn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_op,
    input  logic  i_last,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_P1_RD, S_P1_ACC, S_P1_INIT, S_P1_DIV, S_P1_WR,
        S_P2_RD, S_P2_X, S_P2_WR, S_R_RD, S_R_MLO, S_R_MHI, S_R_DIV,
        S_R_OUT, S_E_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = i_last ? S_PREP : S_IDLE;
                    end else begin
                        n_state = i_stat.rd_ok ? S_R_RD : S_E_OUT;
                    end
                end
            end
            S_PREP: begin
                o_cmd.pass_start = 1'b1;
                n_state = i_stat.detrend ? S_P1_RD : S_P2_RD;
            end
            S_P1_RD:   n_state = S_P1_ACC;
            S_P1_ACC: begin
                o_cmd.p1_acc = 1'b1;
                n_state      = S_P1_INIT;
            end
            S_P1_INIT: begin
                o_cmd.p1_init = 1'b1;
                n_state       = S_P1_DIV;
            end
            S_P1_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_P1_WR;
                end
            end
            S_P1_WR: begin
                o_cmd.p1_wr = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = S_P2_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P1_RD;
                end
            end
            S_P2_RD:   n_state = S_P2_X;
            S_P2_X: begin
                o_cmd.p2_x = 1'b1;
                n_state    = S_P2_WR;
            end
            S_P2_WR: begin
                o_cmd.p2_wr = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_P2_RD;
                end
            end
            S_R_RD: begin
                o_cmd.sel_rp = 1'b1;
                n_state      = S_R_MLO;
            end
            S_R_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_R_MHI;
            end
            S_R_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_R_DIV;
            end
            S_R_DIV: begin
                o_cmd.ndiv_step = 1'b1;
                if (i_stat.ndiv_last) begin
                    n_state = S_R_OUT;
                end
            end
            S_R_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_data = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_E_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

/* design/dpcmdn_dp.sv */
module dpcmdn_dp
    import dpcmdn_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [7:0]  i_delta,
    input  logic [WIN_W-1:0]   i_dc_window,
    input  logic               i_out_ready,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic signed [15:0] o_pcm,
    output logic               o_final,
    output logic               o_empty
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int XW = ((CW > WIN_W) ? CW : WIN_W) + 1;
    localparam int DCW = $clog2(DIV_STEPS);
    localparam int NCW = $clog2(NDIV_STEPS);
    localparam int LOW_W = 25;
    localparam int HIGH_W = VAL_W - LOW_W;

    logic [SUM_W-1:0] mem_sum [MAX_LEN];
    logic [VAL_W-1:0] mem_avg [MAX_LEN];

    logic [CW-1:0]           r_count, r_rp;
    logic [SUM_W-1:0]        r_rsum;
    logic [VAL_W-1:0]        r_peak;
    logic                    r_ready;
    logic                    r_o_valid, r_o_final, r_o_empty;
    logic signed [15:0]      r_o_pcm;
    logic [AW-1:0]           r_idx;
    logic signed [RUN_W-1:0] r_run;
    logic [WIN_W-1:0]        r_div, r_rem;
    logic [DIV_STEPS-1:0]    r_dq;
    logic [DCW-1:0]          r_dcnt;
    logic signed [VAL_W-1:0] r_x;
    logic [SUM_W-1:0]        r_sa, r_sb;
    logic signed [VAL_W-1:0] r_aq;
    logic [LOW_W+14:0]       r_plo;
    logic [HIGH_W-1:0]       r_mhi;
    logic                    r_neg;
    logic [VAL_W-1:0]        r_nrem;
    logic [NDIV_STEPS-1:0]   r_ndq;
    logic [NCW-1:0]          r_ncnt;

    logic [CW-1:0]      ld_cnt;
    logic [SUM_W-1:0]   ld_sum, ld_new;
    logic               ld_ok;
    logic [XW-1:0]      idx_x, w_x, cnt_x, idx_p1, jx, cm1;
    logic               idx_ge_w;
    logic [AW-1:0]      addr_b, addr_j, addr_avg;
    logic [WIN_W-1:0]   div_val;
    logic [RUN_W-1:0]   run_mag;
    logic [WIN_W:0]     dt;
    logic               dge;
    logic [RUN_W-1:0]   q48;
    logic [VAL_W-1:0]   avg_w, x_mag, aq_mag;
    logic [63:0]        prod;
    logic [VAL_W:0]     nt;
    logic               nge;
    logic [15:0]        q_ext;
    logic               fin;
    logic               detrend;

    assign ld_cnt = r_ready ? '0 : r_count;
    assign ld_sum = r_ready ? '0 : r_rsum;
    assign ld_new = ld_sum + {{(SUM_W-8){i_delta[7]}}, i_delta};
    assign ld_ok  = ld_cnt < CW'(MAX_LEN);

    assign idx_x    = XW'(r_idx);
    assign w_x      = XW'(i_dc_window);
    assign cnt_x    = XW'(r_count);
    assign idx_p1   = idx_x + XW'(1);
    assign idx_ge_w = idx_x >= w_x;
    assign addr_b   = AW'(idx_x - w_x);
    assign div_val  = idx_ge_w ? i_dc_window : idx_p1[WIN_W-1:0];
    assign jx       = idx_x + XW'(i_dc_window[WIN_W-1:1]);
    assign cm1      = cnt_x - XW'(1);
    assign addr_j   = (jx < cnt_x) ? jx[AW-1:0] : cm1[AW-1:0];
    assign addr_avg = i_cmd.sel_rp ? r_rp[AW-1:0] : addr_j;
    assign detrend  = (w_x > XW'(1)) && (w_x < cnt_x);

    assign run_mag = r_run[RUN_W-1] ? RUN_W'(-r_run) : RUN_W'(r_run);
    assign dt      = {r_rem, r_dq[DIV_STEPS-1]};
    assign dge     = dt >= {1'b0, r_div};
    assign q48     = r_run[RUN_W-1] ? -r_dq[RUN_W-1:0] : r_dq[RUN_W-1:0];
    assign avg_w   = {q48[RUN_W-1], q48};
    assign x_mag   = r_x[VAL_W-1] ? VAL_W'(-r_x) : VAL_W'(r_x);
    assign aq_mag  = r_aq[VAL_W-1] ? VAL_W'(-r_aq) : VAL_W'(r_aq);
    assign prod    = {(39'(r_mhi) * 39'(NORM_SCALE)), {LOW_W{1'b0}}}
                   + {{(64-LOW_W-15){1'b0}}, r_plo};
    assign nt      = {r_nrem, r_ndq[NDIV_STEPS-1]};
    assign nge     = nt >= {1'b0, r_peak};
    assign q_ext   = {1'b0, r_ndq};
    assign fin     = (r_rp + CW'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        r_sa <= mem_sum[r_idx];
        r_sb <= mem_sum[addr_b];
        r_aq <= mem_avg[addr_avg];
        if (i_cmd.load && ld_ok) begin
            mem_sum[ld_cnt[AW-1:0]] <= ld_new;
        end
        if (i_cmd.p1_wr) begin
            mem_avg[r_idx] <= avg_w;
        end else if (i_cmd.p2_wr) begin
            mem_avg[r_idx] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_start) begin
            r_idx <= '0;
            r_run <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.p1_acc) begin
            r_run <= r_run + RUN_W'($signed(r_sa))
                   - (idx_ge_w ? RUN_W'($signed(r_sb)) : RUN_W'(0));
        end
        if (i_cmd.p1_init) begin
            r_div  <= div_val;
            r_rem  <= '0;
            r_dq   <= {run_mag, {FRAC_BITS{1'b0}}};
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= dge ? WIN_W'(dt - {1'b0, r_div}) : dt[WIN_W-1:0];
            r_dq   <= {r_dq[DIV_STEPS-2:0], dge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
        if (i_cmd.p2_x) begin
            r_x <= {r_sa[SUM_W-1], r_sa, {FRAC_BITS{1'b0}}}
                 - (detrend ? r_aq : VAL_W'(0));
        end
        if (i_cmd.mul_lo) begin
            r_plo <= 40'(aq_mag[LOW_W-1:0]) * 40'(NORM_SCALE);
            r_mhi <= aq_mag[VAL_W-1:LOW_W];
            r_neg <= r_aq[VAL_W-1];
        end
        if (i_cmd.mul_hi) begin
            r_nrem <= prod[63:NDIV_STEPS];
            r_ndq  <= prod[NDIV_STEPS-1:0];
            r_ncnt <= '0;
        end else if (i_cmd.ndiv_step) begin
            r_nrem <= nge ? VAL_W'(nt - {1'b0, r_peak}) : nt[VAL_W-1:0];
            r_ndq  <= {r_ndq[NDIV_STEPS-2:0], nge};
            r_ncnt <= r_ncnt + NCW'(1);
        end
        if (i_cmd.out_data) begin
            r_o_pcm   <= r_neg ? -$signed(q_ext) : $signed(q_ext);
            r_o_final <= fin;
            r_o_empty <= 1'b0;
        end else if (i_cmd.out_empty) begin
            r_o_pcm   <= '0;
            r_o_final <= 1'b1;
            r_o_empty <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rp      <= '0;
            r_rsum    <= '0;
            r_peak    <= '0;
            r_ready   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ready <= 1'b0;
                r_peak  <= '0;
                r_rp    <= '0;
                if (ld_ok) begin
                    r_count <= ld_cnt + CW'(1);
                    r_rsum  <= ld_new;
                end else begin
                    r_count <= ld_cnt;
                    r_rsum  <= ld_sum;
                end
            end
            if (i_cmd.pass_start) begin
                r_peak <= '0;
            end
            if (i_cmd.p2_wr && (x_mag > r_peak)) begin
                r_peak <= x_mag;
            end
            if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
            if ((i_cmd.out_data && fin) || (i_cmd.out_empty && r_ready)) begin
                r_count <= '0;
                r_rp    <= '0;
                r_rsum  <= '0;
                r_peak  <= '0;
                r_ready <= 1'b0;
            end else if (i_cmd.out_data) begin
                r_rp <= r_rp + CW'(1);
            end
            if (i_cmd.out_data || i_cmd.out_empty) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.detrend   = detrend;
        o_stat.idx_last  = idx_p1 == cnt_x;
        o_stat.div_last  = r_dcnt == DCW'(DIV_STEPS - 1);
        o_stat.ndiv_last = r_ncnt == NCW'(NDIV_STEPS - 1);
        o_stat.rd_ok     = r_ready && (r_peak != '0) && (r_rp < r_count);
        o_stat.out_free  = !r_o_valid || i_out_ready;
    end

    assign o_out_valid = r_o_valid;
    assign o_pcm       = r_o_pcm;
    assign o_final     = r_o_final;
    assign o_empty     = r_o_empty;

endmodule

/* design/delta_pcm_decode_detrend_normalize.sv */
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: delta, tuser: op, tlast: last
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: pcm, tuser: empty_res, tlast: final_res
// cfg       | in  | i_cfg_we                     | i_cfg_wdata: dc_window
//
// a load that is not the last leaves the block idle and ready for the next; a read runs
// through the split multiply and the 15-step normalizing divider
// after the last byte, drift removal (window above 1 and below the point count) runs the
// 64-step average divider for each point, then a detrend and peak pass covers every point
// synchronous active-low reset; stores are not cleared
// a result waiting on m_axis does not stop new loads; a read waits for it
module delta_pcm_decode_detrend_normalize
    import dpcmdn_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] delta
    input  logic             s_axis_tuser,   // [0] op
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] pcm
    output logic             m_axis_tuser,   // [0] empty_res
    output logic             m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    logic [WIN_W-1:0]   r_dc_window;
    t_cmd               cmd;
    t_stat              stat;
    logic signed [15:0] pcm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_window <= '0;
        end else if (i_cfg_we) begin
            r_dc_window <= i_cfg_wdata;
        end
    end

    dpcmdn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    dpcmdn_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_delta     ($signed(s_axis_tdata)),
        .i_dc_window (r_dc_window),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_pcm       (pcm),
        .o_final     (m_axis_tlast),
        .o_empty     (m_axis_tuser)
    );

    assign m_axis_tdata = pcm;

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 16'd0))
        else $error("empty result without final flag or with nonzero pcm");

    a_pcm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd30000)
                       && ($signed(m_axis_tdata) >= -16'sd30000))
        else $error("pcm outside normalized range");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_READ) |=> !s_axis_tready)
        else $error("read transaction did not occupy the block");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import dpcmdn_pkg::*;

    localparam int BUF_LEN = 512;
    localparam int LONG_LEN = 300;
    localparam int SETTLE_CYC = 72 * LONG_LEN + 200;

    typedef struct {
        logic       op;
        logic [7:0] delta;
        logic       last;
    } t_byte_item;

    typedef struct {
        logic [15:0] pcm;
        logic        fin;
        logic        emp;
    } t_pcm_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] delta
    logic        s_axis_tuser = 1'b0; // [0] op
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [15:0] pcm
    logic        m_axis_tuser;        // [0] empty_res
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    delta_pcm_decode_detrend_normalize i_dut (.*);

    always #5 i_clk = ~i_clk;

    t_byte_item  pend_q[$];
    t_pcm_word   pcm_exp_q[$];
    int          err_cnt = 0;
    int          item_cnt = 0;
    int          pcm_cnt = 0;
    int          empty_cnt = 0;
    int          sample_cnt = 0;
    bit          quiet = 1'b0;
    bit          tx_acc = 1'b0;
    int          tx_idle = 0;
    int          rx_idle = 0;

    // decoder state
    logic signed [31:0] sums[BUF_LEN];
    longint             vals[BUF_LEN];
    logic        [31:0] run_sum;
    int                 n_pts;
    longint unsigned    peak;
    int                 rd_ptr;
    bit                 ready;
    int                 win;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    task automatic clear_run();
        run_sum = '0;
        n_pts = 0;
        peak = 0;
        rd_ptr = 0;
        ready = 1'b0;
    endtask

    task automatic detrend_and_peak();
        longint run;
        longint unsigned q;
        int dv, j, half;
        if (win > 1 && win < n_pts) begin
            run = 0;
            half = win / 2;
            for (int i = 0; i < n_pts; i++) begin
                run += longint'(sums[i]);
                if (i >= win) run -= longint'(sums[i - win]);
                dv = (i < win) ? i + 1 : win;
                q = (mag(run) << 16) / longint'(dv);
                vals[i] = run < 0 ? -longint'(q) : longint'(q);
            end
            for (int i = 0; i < n_pts; i++) begin
                j = (i + half < n_pts) ? i + half : n_pts - 1;
                vals[i] = longint'(sums[i]) * 65536 - vals[j];
            end
        end else begin
            for (int i = 0; i < n_pts; i++) vals[i] = longint'(sums[i]) * 65536;
        end
        peak = 0;
        for (int i = 0; i < n_pts; i++)
            if (mag(vals[i]) > peak) peak = mag(vals[i]);
        ready = 1'b1;
    endtask

    task automatic decode_step(t_byte_item it);
        t_pcm_word r;
        longint unsigned q;
        longint v;
        if (it.op == OP_LOAD) begin
            if (ready) clear_run();
            if (n_pts < MAX_LEN_DEF) begin
                run_sum = run_sum + {{24{it.delta[7]}}, it.delta};
                sums[n_pts] = run_sum;
                n_pts++;
            end
            if (it.last && n_pts > 0) detrend_and_peak();
            return;
        end
        r = '{pcm: 16'd0, fin: 1'b1, emp: 1'b1};
        if (ready) begin
            if (peak == 0 || rd_ptr >= n_pts) begin
                clear_run();
            end else begin
                v = vals[rd_ptr];
                q = (mag(v) * 30000) / peak;
                v = v < 0 ? -longint'(q) : longint'(q);
                r.pcm = v[15:0];
                r.emp = 1'b0;
                r.fin = (rd_ptr + 1 == n_pts);
                rd_ptr++;
                if (r.fin) clear_run();
            end
        end
        pcm_exp_q = {pcm_exp_q, r};
    endtask

    // input side: track accepted transactions and config writes
    always @(posedge i_clk) begin
        t_byte_item it;
        tx_acc <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_we) win = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                it = '{op: s_axis_tuser, delta: s_axis_tdata, last: s_axis_tlast};
                decode_step(it);
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_byte_item it;
        if (i_rst_n && (!s_axis_tvalid || tx_acc)) begin
            if (tx_idle > 0) begin
                tx_idle--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                tx_idle = $urandom_range(1, 16) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                it = pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= it.op;
                s_axis_tdata <= it.delta;
                s_axis_tlast <= it.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (rx_idle > 0) begin
            rx_idle--;
            m_axis_tready <= 1'b0;
        end else if (quiet || $urandom_range(0, 9) != 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_idle = $urandom_range(1, 16) - 1;
            m_axis_tready <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pcm_word e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pcm_exp_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected transaction: pcm %0d final %0b empty %0b",
                             $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
            end else begin
                e = pcm_exp_q.pop_front();
                if (e.emp) empty_cnt++; else pcm_cnt++;
                if (m_axis_tdata !== e.pcm || m_axis_tlast !== e.fin ||
                    m_axis_tuser !== e.emp) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp pcm %0d fin %0b emp %0b, got pcm %0d fin %0b emp %0b",
                                 $signed(e.pcm), e.fin, e.emp, $signed(m_axis_tdata),
                                 m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    task automatic push(logic op, logic [7:0] d, logic last);
        t_byte_item it;
        it = '{op: op, delta: d, last: last};
        pend_q = {pend_q, it};
        item_cnt++;
    endtask

    // one sample: kind 0 random, 1 all zero, 2 small drift-heavy steps
    task automatic add_sample(int n, int kind, int reads);
        logic [7:0] d;
        for (int i = 0; i < n; i++) begin
            case (kind)
                1: d = 8'd0;
                2: d = 8'($urandom_range(0, 6) - 2);
                default: d = 8'($urandom);
            endcase
            push(OP_LOAD, d, i == n - 1);
        end
        for (int i = 0; i < reads; i++) push(OP_READ, 8'($urandom), 1'($urandom));
        sample_cnt++;
    endtask

    task automatic drain_and_config(logic [15:0] w);
        wait (pend_q.size() == 0 && !s_axis_tvalid && pcm_exp_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        wait (s_axis_tready);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int items);
        int n, r;
        while (items > 0) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                push(1'($urandom), 8'($urandom), 1'($urandom));
                items--;
            end else begin
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(150, LONG_LEN)
                                                 : $urandom_range(1, 40);
                case ($urandom_range(0, 5))
                    0: add_sample(n, 0, $urandom_range(0, n));
                    1: add_sample(n, 0, n + 1);
                    2: add_sample(n, 2, n);
                    3: add_sample(n, $urandom_range(0, 15) == 0 ? 1 : 0, n);
                    default: add_sample(n, 0, n);
                endcase
                items -= 2 * n;
            end
        end
    endtask

    initial begin
        logic [15:0] wins[6] = '{16'd1, 16'd2, 16'd3, 16'd8, 16'd65535, 16'd0};
        win = 0;
        clear_run();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty reads, extremes, zero peak, single point, broken run
        push(OP_READ, 8'h00, 1'b0);
        add_sample(1, 0, 0);
        push(OP_LOAD, 8'h7f, 1'b1);
        push(OP_READ, 8'hff, 1'b1);
        push(OP_READ, 8'h00, 1'b0);
        push(OP_LOAD, 8'h80, 1'b1);
        push(OP_READ, 8'h00, 1'b0);
        add_sample(3, 1, 2);
        push(OP_LOAD, 8'h80, 1'b0);
        push(OP_LOAD, 8'h7f, 1'b0);
        push(OP_LOAD, 8'h01, 1'b1);
        push(OP_READ, 8'h00, 1'b0);
        push(OP_LOAD, 8'h55, 1'b0);
        push(OP_READ, 8'haa, 1'b0);
        push(OP_LOAD, 8'h2a, 1'b1);
        push(OP_READ, 8'h00, 1'b0);
        push(OP_READ, 8'h00, 1'b0);
        push(OP_READ, 8'h00, 1'b0);

        drain_and_config(16'd4);
        add_sample(6, 0, 6);
        add_sample(4, 0, 4);
        add_sample(5, 2, 6);
        random_phase(200);

        foreach (wins[k]) begin
            drain_and_config(k == 2 ? 16'($urandom_range(4, 40)) : wins[k]);
            if (k == 5) quiet = 1'b1;
            random_phase(260);
        end

        wait (pend_q.size() == 0 && !s_axis_tvalid && pcm_exp_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("ran %0d input transactions over %0d samples, several window settings",
                 item_cnt, sample_cnt);
        $display("checked %0d pcm values and %0d empty results", pcm_cnt, empty_cnt);
        if (err_cnt == 0) begin
            $display("[delta_pcm_decode_detrend_normalize] OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("[delta_pcm_decode_detrend_normalize] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("[delta_pcm_decode_detrend_normalize] ERROR");
        $finish;
    end

endmodule
